### rtl/gn3d_pkg.sv
// Package for the 3-D gradient noise pipeline: widths, fixed-point constants
// and the corner gradient function. No dependencies.
`default_nettype none

package gn3d_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_W     = 24;
    localparam int TBL_AW      = 8;
    localparam int TABLE_DEPTH = 1 << TBL_AW;
    localparam int HASH_W      = 8;
    localparam int IDATA_W     = 2 * HASH_W + 3 * COORD_W;
    localparam int OUT_W       = 18;
    localparam int ODATA_W     = ((OUT_W + 7) / 8) * 8;

    localparam int FQ_W  = FRAC_BITS + 1;
    localparam int FR_W  = FRAC_BITS + 2;
    localparam int GR_W  = FRAC_BITS + 3;
    localparam int VAL_W = FRAC_BITS + 6;
    localparam int TT_W  = 2 * FRAC_BITS + 1;
    localparam int KW    = FRAC_BITS + 7;
    localparam int PP_W  = FRAC_BITS + 1 + KW;
    localparam int PI_W  = FRAC_BITS + 6;
    localparam int T3_W  = FQ_W + FRAC_BITS + 1;
    localparam int FP_W  = FQ_W + PI_W;
    localparam int LM_W  = FQ_W + 1 + VAL_W;

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint HALF = ONE >> 1;

    localparam logic [3:0] H_X_ALT0 = 4'd12;
    localparam logic [3:0] H_X_ALT1 = 4'd14;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic signed [VAL_W-1:0] OUT_MAX_V = VAL_W'(131071);
    localparam logic signed [VAL_W-1:0] OUT_MIN_V = VAL_W'(-131072);

    function automatic logic signed [GR_W-1:0] grad(
        input logic [3:0]             h,
        input logic signed [FR_W-1:0] x,
        input logic signed [FR_W-1:0] y,
        input logic signed [FR_W-1:0] z
    );
        logic signed [FR_W-1:0] u;
        logic signed [FR_W-1:0] v;
        logic signed [GR_W-1:0] eu;
        logic signed [GR_W-1:0] ev;
        u  = h[3] ? y : x;
        v  = (h[3:2] == 2'b00) ? y : ((h == H_X_ALT0 || h == H_X_ALT1) ? x : z);
        eu = GR_W'(u);
        ev = GR_W'(v);
        if (h[0])
        begin
            eu = -eu;
        end
        if (h[1])
        begin
            ev = -ev;
        end
        return eu + ev;
    endfunction

endpackage

`default_nettype wire

### rtl/gn3d_ram.sv
// Generic single-write, dual-read RAM with registered, enabled reads.
// No dependencies.
`default_nettype none

module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

`default_nettype wire

### rtl/gradient_noise_3d.sv
// 3-D improved gradient noise, 11-stage pipeline plus output register and skid.
// Throughput: 1 item/cycle while the skid register is empty (s_tready low otherwise).
// Hash lookups use three RAM stages (7 copies of the table), each written by
// load items as they pass, so table order matches item order.
// Load items give no result. Reset (rst_n low, async) clears valid bits only;
// the permutation table is undefined until loaded.
`default_nettype none

module gradient_noise_3d
    import gn3d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // table_index, table_value, x_coord, y_coord, z_coord
    input  wire logic [IDATA_W-1:0] s_tdata,
    // func
    input  wire logic               s_tuser,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // noise_value, zero fill
    output logic [ODATA_W-1:0]      m_tdata
);

    localparam int NSTG = 11;

    logic en;
    logic acc;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // stage 1
    logic                func1_reg;
    logic [HASH_W-1:0]   tidx1_reg, tval1_reg;
    logic [COORD_W-1:0]  crd1_reg [3];
    // stage 2
    logic                func2_reg;
    logic [HASH_W-1:0]   tidx2_reg, tval2_reg, yi2_reg, zi2_reg;
    logic [FRAC_BITS-1:0] fr2_reg [3];
    logic [FQ_W-1:0]     tt2_reg [3];
    logic signed [PI_W-1:0] pi2_reg [3];
    // stage 3
    logic                func3_reg;
    logic [HASH_W-1:0]   tidx3_reg, tval3_reg, zi3_reg;
    logic [FRAC_BITS-1:0] fr3_reg [3];
    logic [FQ_W-1:0]     t3_3_reg [3];
    logic signed [PI_W-1:0] in3_reg [3];
    // stage 4
    logic [FRAC_BITS-1:0] fr4_reg [3];
    logic [FQ_W-1:0]     fd4_reg [3];
    // stages 5..11
    logic [FQ_W-1:0]     fd5_reg [3], fd6_reg [3], fd7_reg [3], fd8_reg [3];
    logic [FQ_W-1:0]     fd9_reg [3], fd10_reg [3];
    logic signed [GR_W-1:0]  ga5_reg [4], gb5_reg [4];
    logic signed [VAL_W-1:0] a6_reg [4], d6_reg [4], a7_reg [4], m7_reg [4];
    logic signed [VAL_W-1:0] a8_reg [2], d8_reg [2], a9_reg [2], m9_reg [2];
    logic signed [VAL_W-1:0] a10_reg, d10_reg, a11_reg, m11_reg;

    // output side
    logic              out_vld_reg, skid_vld_reg;
    logic [OUT_W-1:0]  out_data_reg, skid_data_reg;
    logic [OUT_W-1:0]  res;

    // RAM data
    logic [HASH_W-1:0] r1a, r1b;
    logic [HASH_W-1:0] r2 [4];
    logic [HASH_W-1:0] r3 [8];
    logic [HASH_W-1:0] a_hash, b_hash;
    logic [HASH_W-1:0] h2 [4];

    // combinational stage results
    logic [FQ_W-1:0]        tt_next [3];
    logic signed [PI_W-1:0] pi_next [3];
    logic [FQ_W-1:0]        t3_next [3];
    logic signed [PI_W-1:0] in_next [3];
    logic [FQ_W-1:0]        fd_next [3];
    logic signed [GR_W-1:0] ga_next [4], gb_next [4];
    logic signed [VAL_W-1:0] m_next [4], l_next [4];
    logic signed [VAL_W-1:0] m2_next [2], k_next [2];
    logic signed [VAL_W-1:0] m3_next, r_next;
    logic signed [FR_W-1:0]  fp [3], gp [3];

    assign en       = !skid_vld_reg;
    assign s_tready = !skid_vld_reg;
    assign acc      = s_tvalid && s_tready;

    // fade, step 1
    always_comb
    begin
        logic [TT_W-1:0]        ttp;
        logic [KW-1:0]          k;
        logic signed [PP_W-1:0] pp;
        for (int i = 0; i < 3; i++)
        begin
            ttp        = TT_W'(crd1_reg[i][FRAC_BITS-1:0]) * TT_W'(crd1_reg[i][FRAC_BITS-1:0]);
            ttp        = ttp + TT_W'(HALF);
            tt_next[i] = ttp[FRAC_BITS+FQ_W-1:FRAC_BITS];
            k          = KW'(crd1_reg[i][FRAC_BITS-1:0]) * KW'(6) - KW'(15 * ONE);
            pp         = $signed({1'b0, crd1_reg[i][FRAC_BITS-1:0]}) * $signed(k);
            pp         = pp + PP_W'(HALF);
            pi_next[i] = pp[FRAC_BITS+PI_W-1:FRAC_BITS];
        end
    end

    // fade, steps 2 and 3
    always_comb
    begin
        logic [T3_W-1:0] t3p;
        logic [FP_W-1:0] fpp;
        for (int i = 0; i < 3; i++)
        begin
            t3p        = T3_W'(tt2_reg[i]) * T3_W'(fr2_reg[i]);
            t3p        = t3p + T3_W'(HALF);
            t3_next[i] = t3p[FRAC_BITS+FQ_W-1:FRAC_BITS];
            in_next[i] = pi2_reg[i] + PI_W'(10 * ONE);
            fpp        = FP_W'(t3_3_reg[i]) * FP_W'(in3_reg[i][PI_W-2:0]);
            fpp        = fpp + FP_W'(HALF);
            fd_next[i] = fpp[FRAC_BITS+FQ_W-1:FRAC_BITS];
        end
    end

    // table RAMs
    gn3d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram1 (
        .clk(clk), .we(en && vld_reg[0] && func1_reg == FUNC_LOAD),
        .waddr(tidx1_reg), .wdata(tval1_reg), .re(en),
        .raddr_a(crd1_reg[0][FRAC_BITS+TBL_AW-1:FRAC_BITS]),
        .raddr_b(crd1_reg[0][FRAC_BITS+TBL_AW-1:FRAC_BITS] + TBL_AW'(1)),
        .rdata_a(r1a), .rdata_b(r1b)
    );

    assign a_hash = r1a + yi2_reg;
    assign b_hash = r1b + yi2_reg;

    gn3d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram2a (
        .clk(clk), .we(en && vld_reg[1] && func2_reg == FUNC_LOAD),
        .waddr(tidx2_reg), .wdata(tval2_reg), .re(en),
        .raddr_a(a_hash), .raddr_b(a_hash + TBL_AW'(1)),
        .rdata_a(r2[0]), .rdata_b(r2[1])
    );

    gn3d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram2b (
        .clk(clk), .we(en && vld_reg[1] && func2_reg == FUNC_LOAD),
        .waddr(tidx2_reg), .wdata(tval2_reg), .re(en),
        .raddr_a(b_hash), .raddr_b(b_hash + TBL_AW'(1)),
        .rdata_a(r2[2]), .rdata_b(r2[3])
    );

    // h2: AA, AB, BA, BB
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            h2[i] = r2[i] + zi3_reg;
        end
    end

    // r3: {AA, AA+1}, {AB, AB+1}, {BA, BA+1}, {BB, BB+1}
    for (genvar g = 0; g < 4; g++)
    begin : g_ram3
        gn3d_ram #(.WIDTH(HASH_W), .DEPTH(TABLE_DEPTH)) u_ram3 (
            .clk(clk), .we(en && vld_reg[2] && func3_reg == FUNC_LOAD),
            .waddr(tidx3_reg), .wdata(tval3_reg), .re(en),
            .raddr_a(h2[g]), .raddr_b(h2[g] + TBL_AW'(1)),
            .rdata_a(r3[2*g]), .rdata_b(r3[2*g+1])
        );
    end

    // corner gradients
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fp[i] = $signed(FR_W'(fr4_reg[i]));
            gp[i] = $signed(FR_W'(fr4_reg[i])) - FR_W'(ONE);
        end
        ga_next[0] = grad(r3[0][3:0], fp[0], fp[1], fp[2]);
        gb_next[0] = grad(r3[4][3:0], gp[0], fp[1], fp[2]);
        ga_next[1] = grad(r3[2][3:0], fp[0], gp[1], fp[2]);
        gb_next[1] = grad(r3[6][3:0], gp[0], gp[1], fp[2]);
        ga_next[2] = grad(r3[1][3:0], fp[0], fp[1], gp[2]);
        gb_next[2] = grad(r3[5][3:0], gp[0], fp[1], gp[2]);
        ga_next[3] = grad(r3[3][3:0], fp[0], gp[1], gp[2]);
        gb_next[3] = grad(r3[7][3:0], gp[0], gp[1], gp[2]);
    end

    // interpolation
    always_comb
    begin
        logic signed [LM_W-1:0] p;
        for (int i = 0; i < 4; i++)
        begin
            p         = $signed({1'b0, fd6_reg[0]}) * d6_reg[i];
            p         = p + LM_W'(HALF);
            m_next[i] = p[FRAC_BITS+VAL_W-1:FRAC_BITS];
            l_next[i] = a7_reg[i] + m7_reg[i];
        end
        for (int i = 0; i < 2; i++)
        begin
            p          = $signed({1'b0, fd8_reg[1]}) * d8_reg[i];
            p          = p + LM_W'(HALF);
            m2_next[i] = p[FRAC_BITS+VAL_W-1:FRAC_BITS];
            k_next[i]  = a9_reg[i] + m9_reg[i];
        end
        p       = $signed({1'b0, fd10_reg[2]}) * d10_reg;
        p       = p + LM_W'(HALF);
        m3_next = p[FRAC_BITS+VAL_W-1:FRAC_BITS];
        r_next  = a11_reg + m11_reg;
        if (r_next > OUT_MAX_V)
        begin
            res = OUT_MAX_V[OUT_W-1:0];
        end
        else if (r_next < OUT_MIN_V)
        begin
            res = OUT_MIN_V[OUT_W-1:0];
        end
        else
        begin
            res = r_next[OUT_W-1:0];
        end
    end

    always_comb
    begin
        vld_next    = vld_reg << 1;
        vld_next[0] = acc;
        vld_next[3] = vld_reg[2] && func3_reg == FUNC_EVAL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func1_reg   <= s_tuser;
            tidx1_reg   <= s_tdata[HASH_W-1:0];
            tval1_reg   <= s_tdata[2*HASH_W-1:HASH_W];
            for (int i = 0; i < 3; i++)
            begin
                crd1_reg[i] <= s_tdata[2*HASH_W+i*COORD_W +: COORD_W];
            end

            func2_reg <= func1_reg;
            tidx2_reg <= tidx1_reg;
            tval2_reg <= tval1_reg;
            yi2_reg   <= crd1_reg[1][FRAC_BITS+TBL_AW-1:FRAC_BITS];
            zi2_reg   <= crd1_reg[2][FRAC_BITS+TBL_AW-1:FRAC_BITS];

            func3_reg <= func2_reg;
            tidx3_reg <= tidx2_reg;
            tval3_reg <= tval2_reg;
            zi3_reg   <= zi2_reg;

            for (int i = 0; i < 3; i++)
            begin
                fr2_reg[i]  <= crd1_reg[i][FRAC_BITS-1:0];
                tt2_reg[i]  <= tt_next[i];
                pi2_reg[i]  <= pi_next[i];
                fr3_reg[i]  <= fr2_reg[i];
                t3_3_reg[i] <= t3_next[i];
                in3_reg[i]  <= in_next[i];
                fr4_reg[i]  <= fr3_reg[i];
                fd4_reg[i]  <= fd_next[i];
                fd5_reg[i]  <= fd4_reg[i];
                fd6_reg[i]  <= fd5_reg[i];
                fd7_reg[i]  <= fd6_reg[i];
                fd8_reg[i]  <= fd7_reg[i];
                fd9_reg[i]  <= fd8_reg[i];
                fd10_reg[i] <= fd9_reg[i];
            end

            for (int i = 0; i < 4; i++)
            begin
                ga5_reg[i] <= ga_next[i];
                gb5_reg[i] <= gb_next[i];
                a6_reg[i]  <= VAL_W'(ga5_reg[i]);
                d6_reg[i]  <= VAL_W'(gb5_reg[i]) - VAL_W'(ga5_reg[i]);
                a7_reg[i]  <= a6_reg[i];
                m7_reg[i]  <= m_next[i];
            end

            a8_reg[0] <= l_next[0];
            a8_reg[1] <= l_next[2];
            d8_reg[0] <= l_next[1] - l_next[0];
            d8_reg[1] <= l_next[3] - l_next[2];
            for (int i = 0; i < 2; i++)
            begin
                a9_reg[i] <= a8_reg[i];
                m9_reg[i] <= m2_next[i];
            end
            a10_reg <= k_next[0];
            d10_reg <= k_next[1] - k_next[0];
            a11_reg <= a10_reg;
            m11_reg <= m3_next;
        end
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (!out_vld_reg || m_tready)
        begin
            if (skid_vld_reg)
            begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end
            else
            begin
                out_vld_reg <= vld_reg[NSTG-1];
            end
        end
        else if (en && vld_reg[NSTG-1])
        begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_vld_reg || m_tready)
        begin
            out_data_reg <= skid_vld_reg ? skid_data_reg : res;
        end
        else if (en)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = ODATA_W'(out_data_reg);

    a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid holds an item while output is empty");

    a_skid_cause : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready && vld_reg[NSTG-1]))
        else $error("skid filled without a stalled output");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

    a_load_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[2] && func3_reg == FUNC_LOAD |=> !vld_reg[3])
        else $error("load item reached the arithmetic stages");

endmodule

`default_nettype wire
